### src/kda_pkg.sv
// Shared types and constants for the keypad debounce and auto-repeat block.
package kda_pkg;

    typedef struct packed {
        logic [4:0] raw_key;
        logic       ptt_down;
        logic       serial_busy;
        logic       tx_time_up;
    } t_in_item;

    typedef struct packed {
        logic [4:0] event_key;
        logic       event_pressed;
        logic       event_held;
        logic       last_event;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_REPEAT_DELAY = 3'd1,
        REG_REPEAT_PER   = 3'd2,
        REG_PTT_TOGGLE   = 3'd3,
        REG_CODE_PTT     = 3'd4,
        REG_CODE_UP      = 3'd5,
        REG_CODE_DOWN    = 3'd6,
        REG_CODE_NONE    = 3'd7
    } t_reg_addr;

    localparam logic [1:0]  PTT_DEBOUNCE   = 2'd3;
    localparam logic [15:0] COUNT_TOP      = 16'hFFFF;
    localparam int          DIV_STEPS      = 16;
    localparam int          QUEUE_DEPTH    = 3;

    localparam logic [7:0]  RST_DEBOUNCE   = 8'd2;
    localparam logic [9:0]  RST_DELAY      = 10'd40;
    localparam logic [7:0]  RST_PERIOD     = 8'd8;
    localparam logic [4:0]  RST_CODE_PTT   = 5'd21;
    localparam logic [4:0]  RST_CODE_UP    = 5'd11;
    localparam logic [4:0]  RST_CODE_DOWN  = 5'd12;
    localparam logic [4:0]  RST_CODE_NONE  = 5'd31;

endpackage

### src/keypad_debounce_autorepeat.sv
// Top level: keypad and push-to-talk debounce with auto-repeat, serial remainder unit.
// Each tick passes through the push-to-talk state, the bit-serial remainder unit and
// the key state, then hands its queued events out one at a time as the output takes
// them. A new input is accepted only in idle, so a tick must finish before the next.
// Synchronous active-low reset restores the defaults and clears the control state.
module keypad_debounce_autorepeat (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kda_pkg::t_in_item     i_in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output kda_pkg::t_out_item    o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import kda_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PTT,
        ST_DIV,
        ST_KEY,
        ST_EMIT
    } t_state;

    t_state     r_state, n_state;

    logic [7:0] r_debounce;
    logic [9:0] r_delay;
    logic [7:0] r_period;
    logic       r_toggle;
    logic [4:0] r_code_ptt, r_code_up, r_code_down, r_code_none;

    t_in_item   r_in, n_in;
    logic [4:0] r_last_raw, n_last_raw;
    logic [4:0] r_stable, n_stable;
    logic [15:0] r_hold, n_hold;
    logic       r_held, n_held;
    logic       r_lat, n_lat;
    logic [1:0] r_pcnt, n_pcnt;
    logic       r_tx, n_tx;

    logic [7:0] r_rem, n_rem;
    logic [15:0] r_dvd, n_dvd;
    logic [7:0] r_div, n_div;
    logic [3:0] r_step, n_step;

    t_out_item  r_q [QUEUE_DEPTH];
    t_out_item  n_q [QUEUE_DEPTH];
    logic [1:0] r_qcnt, n_qcnt;
    logic [1:0] r_rd, n_rd;

    t_out_item  r_out, n_out;
    logic       r_out_valid, n_out_valid;

    logic       cfg_wr;
    logic [15:0] hc1;
    logic [8:0] trial;
    t_reg_addr  addr;

    assign addr      = t_reg_addr'(paddr[4:2]);
    assign cfg_wr    = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign in_ready  = (r_state == ST_IDLE);
    assign out_valid = r_out_valid;
    assign o_out_item = r_out;
    assign hc1       = r_hold + 16'd1;
    assign trial     = {r_rem, r_dvd[15]};

    always_comb begin
        unique case (addr)
            REG_DEBOUNCE:     prdata = {24'd0, r_debounce};
            REG_REPEAT_DELAY: prdata = {22'd0, r_delay};
            REG_REPEAT_PER:   prdata = {24'd0, r_period};
            REG_PTT_TOGGLE:   prdata = {31'd0, r_toggle};
            REG_CODE_PTT:     prdata = {27'd0, r_code_ptt};
            REG_CODE_UP:      prdata = {27'd0, r_code_up};
            REG_CODE_DOWN:    prdata = {27'd0, r_code_down};
            REG_CODE_NONE:    prdata = {27'd0, r_code_none};
            default:          prdata = 32'd0;
        endcase
    end

    always_comb begin
        t_out_item ev;
        logic      push;
        logic [1:0] c1;

        n_state     = r_state;
        n_in        = r_in;
        n_last_raw  = r_last_raw;
        n_stable    = r_stable;
        n_hold      = r_hold;
        n_held      = r_held;
        n_lat       = r_lat;
        n_pcnt      = r_pcnt;
        n_tx        = r_tx;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_div       = r_div;
        n_step      = r_step;
        n_q         = r_q;
        n_qcnt      = r_qcnt;
        n_rd        = r_rd;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ev          = '0;
        push        = 1'b0;
        c1          = 2'd0;

        if (r_out_valid && out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_valid) begin
                    n_in    = i_in_item;
                    n_state = ST_PTT;
                end
            end
            ST_PTT: begin
                n_qcnt = 2'd0;
                if (r_tx && r_in.tx_time_up) begin
                    n_q[n_qcnt] = '{r_code_ptt, 1'b0, 1'b0, 1'b0};
                    n_qcnt      = n_qcnt + 2'd1;
                    n_tx        = 1'b0;
                    n_lat       = 1'b0;
                end
                if (r_in.ptt_down && !r_in.serial_busy) begin
                    if (!n_lat) begin
                        c1 = r_pcnt + 2'd1;
                        if (c1 >= PTT_DEBOUNCE) begin
                            n_lat  = 1'b1;
                            n_pcnt = 2'd0;
                            if (r_toggle && n_tx) begin
                                n_q[n_qcnt] = '{r_code_ptt, 1'b0, 1'b0, 1'b0};
                                n_qcnt      = n_qcnt + 2'd1;
                                n_tx        = 1'b0;
                            end else if (!n_tx) begin
                                n_q[n_qcnt] = '{r_code_ptt, 1'b1, 1'b0, 1'b0};
                                n_qcnt      = n_qcnt + 2'd1;
                                n_tx        = 1'b1;
                            end
                        end else begin
                            n_pcnt = c1;
                        end
                    end else begin
                        n_pcnt = 2'd0;
                    end
                end else begin
                    if (n_lat && !r_toggle && n_tx) begin
                        n_q[n_qcnt] = '{r_code_ptt, 1'b0, 1'b0, 1'b0};
                        n_qcnt      = n_qcnt + 2'd1;
                        n_tx        = 1'b0;
                    end
                    n_lat  = 1'b0;
                    n_pcnt = 2'd0;
                end
                n_rem   = 8'd0;
                n_dvd   = hc1;
                n_div   = r_period;
                n_step  = 4'd0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_div}) begin
                    n_rem = 8'(trial - {1'b0, r_div});
                end else begin
                    n_rem = trial[7:0];
                end
                n_dvd  = {r_dvd[14:0], 1'b0};
                n_step = r_step + 4'd1;
                if (r_step == 4'(DIV_STEPS - 1)) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                if (r_last_raw != r_in.raw_key) begin
                    if (r_last_raw != r_code_none && r_in.raw_key != r_code_none) begin
                        push = 1'b1;
                        ev   = '{r_stable, 1'b0, r_held, 1'b0};
                    end
                    n_last_raw = r_in.raw_key;
                    n_hold     = 16'd0;
                end else begin
                    n_hold = hc1;
                    if (hc1 == {8'd0, r_debounce}) begin
                        if (r_in.raw_key == r_code_none) begin
                            if (r_stable != r_code_none) begin
                                push     = 1'b1;
                                ev       = '{r_stable, 1'b0, r_held, 1'b0};
                                n_stable = r_code_none;
                            end
                        end else begin
                            n_stable = r_in.raw_key;
                            push     = 1'b1;
                            ev       = '{r_in.raw_key, 1'b1, 1'b0, 1'b0};
                        end
                        n_held = 1'b0;
                    end else if (hc1 < {6'd0, r_delay} || r_in.raw_key == r_code_none) begin
                        n_hold = hc1;
                    end else if (hc1 == {6'd0, r_delay}) begin
                        if (r_in.raw_key != r_code_ptt) begin
                            n_held = 1'b1;
                            push   = 1'b1;
                            ev     = '{r_in.raw_key, 1'b1, 1'b1, 1'b0};
                        end
                    end else begin
                        if (r_in.raw_key == r_code_up || r_in.raw_key == r_code_down) begin
                            n_held = 1'b1;
                            if (r_period != 8'd0 && r_rem == 8'd0) begin
                                push = 1'b1;
                                ev   = '{r_in.raw_key, 1'b1, 1'b1, 1'b0};
                            end
                        end
                        if (hc1 >= COUNT_TOP) begin
                            n_hold = {6'd0, r_delay} + 16'd1;
                        end
                    end
                end
                if (push && r_qcnt != 2'(QUEUE_DEPTH)) begin
                    n_q[r_qcnt] = ev;
                    n_qcnt      = r_qcnt + 2'd1;
                end
                n_rd = 2'd0;
                if (n_qcnt == 2'd0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_rd == r_qcnt) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || out_ready) begin
                    n_out            = r_q[r_rd];
                    n_out.last_event = (r_rd == r_qcnt - 2'd1);
                    n_out_valid      = 1'b1;
                    n_rd             = r_rd + 2'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_div  <= n_div;
        r_step <= n_step;
        r_q    <= n_q;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_debounce  <= RST_DEBOUNCE;
            r_delay     <= RST_DELAY;
            r_period    <= RST_PERIOD;
            r_toggle    <= 1'b0;
            r_code_ptt  <= RST_CODE_PTT;
            r_code_up   <= RST_CODE_UP;
            r_code_down <= RST_CODE_DOWN;
            r_code_none <= RST_CODE_NONE;
            r_last_raw  <= RST_CODE_NONE;
            r_stable    <= RST_CODE_NONE;
            r_hold      <= 16'd0;
            r_held      <= 1'b0;
            r_lat       <= 1'b0;
            r_pcnt      <= 2'd0;
            r_tx        <= 1'b0;
            r_qcnt      <= 2'd0;
            r_rd        <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_raw  <= n_last_raw;
            r_stable    <= n_stable;
            r_hold      <= n_hold;
            r_held      <= n_held;
            r_lat       <= n_lat;
            r_pcnt      <= n_pcnt;
            r_tx        <= n_tx;
            r_qcnt      <= n_qcnt;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                unique case (addr)
                    REG_DEBOUNCE:     r_debounce  <= pwdata[7:0];
                    REG_REPEAT_DELAY: r_delay     <= pwdata[9:0];
                    REG_REPEAT_PER:   r_period    <= pwdata[7:0];
                    REG_PTT_TOGGLE:   r_toggle    <= pwdata[0];
                    REG_CODE_PTT:     r_code_ptt  <= pwdata[4:0];
                    REG_CODE_UP:      r_code_up   <= pwdata[4:0];
                    REG_CODE_DOWN:    r_code_down <= pwdata[4:0];
                    REG_CODE_NONE:    r_code_none <= pwdata[4:0];
                    default:          r_toggle    <= r_toggle;
                endcase
            end
        end
    end

endmodule

### src/kda_checker.sv
// Port-level checker for the keypad debounce block and its bind statement.
module kda_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  kda_pkg::t_out_item o_out_item,
    input  logic               pready
);
    import kda_pkg::*;

    // A stalled result holds its value until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // After an input transaction the block drops in_ready, as a tick is in progress.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input accepted while a tick is in progress");

    // Reset leaves the block ready with no result pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> in_ready && !out_valid)
        else $error("reset did not clear the block");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind keypad_debounce_autorepeat kda_checker u_kda_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .o_out_item (o_out_item),
    .pready     (pready)
);
